>>> rtl/crc_checked_frame_receiver_core_assert.svh
// Assertion macros used by the frame core module (cfr_frame_core).
`ifndef CRC_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/cfr_pkg.sv
package cfr_pkg;

    localparam int MAX_POSITION = 126;
    localparam int POS_W        = $clog2(MAX_POSITION + 1);
    localparam int CMP_W        = ((POS_W > 8) ? POS_W : 8) + 1;
    localparam int BYTE_W       = 8;
    localparam int CRC_W        = 16;
    localparam int PIDX_W       = 7;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int RESULT_W     = 5 * BYTE_W + PIDX_W + STATUS_W;
    localparam int TDATA_W      = ((RESULT_W + 7) / 8) * 8;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h58;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h4A;
    localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'hEE;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GOOD      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_END   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERLENGTH = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] end_marker;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/cfr_cfg_regs.sv
module cfr_cfg_regs
    import cfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data;
                CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data;
                CFG_END_MARKER:  cfg_next.end_marker  = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.end_marker  <= END_MARKER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/cfr_in_reg.sv
module cfr_in_reg
    import cfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              take,
    output beat_t             beat
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // A held beat leaves when the core takes it, so a new one may enter the same cycle.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

>>> rtl/cfr_frame_core.sv
module cfr_frame_core
    import cfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  beat_t              beat,
    output logic               take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser
);

    `include "crc_checked_frame_receiver_core_assert.svh"

    localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DIR     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(6);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] dir_reg, dir_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [CRC_W-1:0]  rx_crc_reg, rx_crc_next;
    logic              end_ok_reg, end_ok_next;

    logic                out_valid_reg, out_valid_next;
    logic                kind_reg;
    logic [BYTE_W-1:0]   pbyte_reg;
    logic [PIDX_W-1:0]   pidx_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [BYTE_W-1:0]   otype_reg, odir_reg, ocmd_reg, olen_reg;

    logic [BYTE_W-1:0]   b;
    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    crc_at;
    logic [POS_W:0]      pos_inc;
    logic [POS_W-1:0]    idx_full;
    logic [CRC_W-1:0]    crc_upd;
    logic                has_res;
    logic                res_kind;
    logic [STATUS_W-1:0] res_status;
    logic                is_payload;
    logic                at_verdict;
    logic                in_frame;

    assign b        = beat.data;
    assign take     = beat.valid && (!out_valid_reg || m_tready);
    assign pos_c    = CMP_W'(pos_reg);
    assign crc_at   = CMP_W'(len_reg) + CMP_W'(POS_PAYLOAD);
    assign pos_inc  = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign idx_full = pos_reg - POS_PAYLOAD;
    assign crc_upd  = crc_byte((pos_reg == POS_TYPE) ? CRC_W'(0) : crc_reg, b);

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        dir_next    = dir_reg;
        cmd_next    = cmd_reg;
        rx_crc_next = rx_crc_reg;
        end_ok_next = end_ok_reg;
        is_payload  = 1'b0;
        at_verdict  = 1'b0;
        in_frame    = 1'b1;
        res_status  = ST_GOOD;

        priority if (pos_reg == POS_HUNT)
        begin
            in_frame = 1'b0;
            if (b == cfg.sync_first)
            begin
                pos_next = POS_SYNC2;
            end
        end
        else if (pos_reg == POS_SYNC2)
        begin
            in_frame = 1'b0;
            if (b == cfg.sync_second)
            begin
                pos_next = POS_TYPE;
                crc_next = '0;
            end
            else if (b != cfg.sync_first)
            begin
                pos_next = POS_HUNT;
            end
        end
        else if (pos_reg == POS_TYPE)
        begin
            type_next = b;
            crc_next  = crc_upd;
        end
        else if (pos_reg == POS_DIR)
        begin
            dir_next = b;
            crc_next = crc_upd;
        end
        else if (pos_reg == POS_CMD)
        begin
            cmd_next = b;
            crc_next = crc_upd;
        end
        else if (pos_reg == POS_LEN)
        begin
            len_next = b;
            crc_next = crc_upd;
        end
        else if (pos_c < crc_at)
        begin
            crc_next   = crc_upd;
            is_payload = 1'b1;
        end
        else if (pos_c == crc_at)
        begin
            rx_crc_next = {b, 8'h00};
        end
        else if (pos_c == crc_at + CMP_W'(1))
        begin
            rx_crc_next = {rx_crc_reg[CRC_W-1:8], b};
        end
        else if (pos_c == crc_at + CMP_W'(2))
        begin
            end_ok_next = (b == cfg.end_marker);
        end
        else
        begin
            at_verdict = 1'b1;
            pos_next   = POS_HUNT;
            if (!(end_ok_reg && (b == cfg.end_marker)))
            begin
                res_status = ST_BAD_END;
            end
            else if (crc_reg != rx_crc_reg)
            begin
                res_status = ST_CRC_ERR;
            end
            else
            begin
                res_status = ST_GOOD;
            end
        end

        has_res  = at_verdict;
        res_kind = KIND_VERDICT;
        if (in_frame && !at_verdict)
        begin
            if (pos_inc > (POS_W + 1)'(MAX_POSITION))
            begin
                pos_next   = POS_HUNT;
                has_res    = 1'b1;
                res_status = ST_OVERLENGTH;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
                has_res  = is_payload;
                res_kind = KIND_PAYLOAD;
            end
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = has_res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HUNT;
            crc_reg       <= '0;
            len_reg       <= '0;
            type_reg      <= '0;
            dir_reg       <= '0;
            cmd_reg       <= '0;
            rx_crc_reg    <= '0;
            end_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                len_reg    <= len_next;
                type_reg   <= type_next;
                dir_reg    <= dir_next;
                cmd_reg    <= cmd_next;
                rx_crc_reg <= rx_crc_next;
                end_ok_reg <= end_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_res)
        begin
            kind_reg   <= res_kind;
            pbyte_reg  <= (res_kind == KIND_PAYLOAD) ? b : BYTE_W'(0);
            pidx_reg   <= (res_kind == KIND_PAYLOAD) ? PIDX_W'(idx_full) : PIDX_W'(0);
            status_reg <= res_status;
            otype_reg  <= type_next;
            odir_reg   <= dir_next;
            ocmd_reg   <= cmd_next;
            olen_reg   <= len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {(TDATA_W - RESULT_W)'(0), status_reg, olen_reg, ocmd_reg, odir_reg,
                       otype_reg, pidx_reg, pbyte_reg};

    `CFR_ASSERT_NOW(a_pos_limit, clk, rst_n, 1'b1, pos_reg <= POS_W'(MAX_POSITION))
    `CFR_ASSERT_NEXT(a_verdict_rehunt, clk, rst_n,
        take && has_res && (res_kind == KIND_VERDICT), pos_reg == POS_HUNT)
    `CFR_ASSERT_NOW(a_payload_status, clk, rst_n,
        out_valid_reg && (kind_reg == KIND_PAYLOAD), status_reg == ST_GOOD)
    `CFR_ASSERT_NEXT(a_stall_holds_state, clk, rst_n,
        beat.valid && !take, $stable(pos_reg) && $stable(crc_reg))

endmodule

>>> rtl/crc_checked_frame_receiver_core.sv
// Receiver for sync-framed packets checked by CRC-16 (poly 0x1021, init 0).
// Raw link bytes enter on the s_* stream, one byte per beat.  The block hunts
// for the two sync bytes, then reads type, direction, command, a length byte,
// the payload, a big-endian CRC and two end markers.
// Every payload byte leaves on the m_* stream as a beat with tuser low; at the
// second end marker, or when a frame runs past the position limit, one verdict
// beat leaves with tuser high and the status field set.
// The cfg_* channel writes the sync and end-marker registers; it is always
// ready and should only be used while no frame is in flight.
// An accepted input beat passes through the input register and then the output
// register before its result beat appears.  Throughput is one byte per cycle
// while m_tready does not stall the output, set by the byte-wise CRC update.
// Reset returns the parser to the sync hunt with the registers at their
// defaults and no beat pending.  When m_tready is low the output register
// holds its beat and s_tready falls once the input register is also full.
module crc_checked_frame_receiver_core
    import cfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // payload_byte, payload_index, frame_type,
                                            // frame_direction, frame_command,
                                            // payload_length, status, zero fill
    output logic                 m_tuser,   // [0] kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t  cfg;
    beat_t beat;
    logic  take;

    cfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfr_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .beat     (beat)
    );

    cfr_frame_core u_frame_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .beat     (beat),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
